// File: hw/rtl/gcs_pkg.sv
// shared types and constants of the gait contact schedule block
package gcs_pkg;

    localparam int TIME_W     = 32;
    localparam int Q_W        = 16;
    localparam int FEET       = 4;
    localparam int MODE_MAX   = 4;
    localparam int MODE_W     = 2;
    localparam int CNT_CFG_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int STEP_W     = 5;

    localparam logic [Q_W:0]        Q_ONE    = 17'h10000;
    localparam logic [STEP_W-1:0]   DIV_LAST = 5'd31;
    localparam logic [STEP_W-1:0]   PH_LAST  = 5'd15;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END0     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CONTACTS = 3'd5;

    localparam logic [TIME_W-1:0]    RST_PERIOD   = 32'd1000;
    localparam logic [CNT_CFG_W-1:0] RST_COUNT    = 3'd1;
    localparam logic [Q_W-1:0]       RST_END0     = 16'd32768;
    localparam logic [Q_W-1:0]       RST_END1     = 16'd49152;
    localparam logic [Q_W-1:0]       RST_END2     = 16'd57344;
    localparam logic [Q_W-1:0]       RST_CONTACTS = 16'd0;

    typedef struct packed {
        logic [TIME_W-1:0]    period;
        logic [CNT_CFG_W-1:0] mode_count;
        logic [Q_W-1:0]       end0;
        logic [Q_W-1:0]       end1;
        logic [Q_W-1:0]       end2;
        logic [Q_W-1:0]       contacts;
    } gcs_cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_PREP,
        S_PHASE,
        S_MODE,
        S_CHECK,
        S_EMIT,
        S_MUL,
        S_OFS,
        S_ADV,
        S_FINAL
    } gcs_state_t;

    typedef struct packed {
        logic load_in;
        logic div_step;
        logic ph_init;
        logic ph_step;
        logic mode_init;
        logic load_brk;
        logic mul_step;
        logic ofs_step;
        logic adv_step;
        logic load_final;
    } gcs_cmd_t;

    typedef struct packed {
        logic go_on;
        logic out_free;
    } gcs_status_t;

endpackage

// File: hw/rtl/gcs_cfg_regs.sv
// configuration register file of the gait contact schedule block
module gcs_cfg_regs
    import gcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output gcs_cfg_t              cfg
);

    gcs_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period     <= RST_PERIOD;
            cfg_reg.mode_count <= RST_COUNT;
            cfg_reg.end0       <= RST_END0;
            cfg_reg.end1       <= RST_END1;
            cfg_reg.end2       <= RST_END2;
            cfg_reg.contacts   <= RST_CONTACTS;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PERIOD:   cfg_reg.period     <= cfg_data[TIME_W-1:0];
                REG_COUNT:    cfg_reg.mode_count <= cfg_data[CNT_CFG_W-1:0];
                REG_END0:     cfg_reg.end0       <= cfg_data[Q_W-1:0];
                REG_END1:     cfg_reg.end1       <= cfg_data[Q_W-1:0];
                REG_END2:     cfg_reg.end2       <= cfg_data[Q_W-1:0];
                REG_CONTACTS: cfg_reg.contacts   <= cfg_data[Q_W-1:0];
                default:      ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/gcs_datapath.sv
// datapath: serial modulo and phase division, boundary arithmetic, output word register
module gcs_datapath
    import gcs_pkg::*;
#(
    parameter int MAX_BREAKS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  gcs_cfg_t          cfg,
    input  gcs_cmd_t          cmd,
    output gcs_status_t       status,
    input  logic [TIME_W-1:0] start_time,
    input  logic [TIME_W-1:0] stop_time,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [TIME_W-1:0] break_time,
    output logic [FEET-1:0]   contact_bits,
    output logic [MODE_W-1:0] mode_index,
    output logic              last_item,
    output logic              truncated
);

    localparam int CNT_W = $clog2(MAX_BREAKS);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_BREAKS - 1);

    logic [TIME_W-1:0]    p;
    logic [CNT_CFG_W-1:0] mode_cnt;
    logic [Q_W:0]         cfg_end [MODE_MAX];
    logic [Q_W:0]         mode_end [MODE_MAX];
    logic [MODE_W-1:0]    found_mode;

    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] stop_reg;
    logic [TIME_W-1:0] s_reg;
    logic [TIME_W-1:0] r_reg;
    logic [TIME_W-1:0] ph_rem_reg;
    logic [Q_W-1:0]    ph_reg;
    logic [TIME_W:0]   base_reg;
    logic [TIME_W:0]   t_reg;
    logic [MODE_W-1:0] m_reg;
    logic [MODE_W-1:0] lastm_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [TIME_W:0]   hi_prod_reg;
    logic [TIME_W:0]   lo_prod_reg;
    logic [TIME_W:0]   ofs_reg;

    logic [TIME_W-1:0] break_time_reg;
    logic [FEET-1:0]   contact_bits_reg;
    logic [MODE_W-1:0] mode_index_reg;
    logic              last_item_reg;
    logic              truncated_reg;
    logic              out_valid_reg;

    logic [TIME_W:0]      div_shift;
    logic [TIME_W:0]      div_sub;
    logic                 div_ge;
    logic [TIME_W-1:0]    r_next;
    logic [TIME_W:0]      ph_diff;
    logic                 ph_ge;
    logic [TIME_W-1:0]    ph_rem_next;
    logic [Q_W:0]         cur_end;
    logic [TIME_W:0]      hi_prod_next;
    logic [TIME_W:0]      lo_prod_next;
    logic [TIME_W:0]      lo_adj;
    logic [TIME_W:0]      ofs_next;
    logic [TIME_W:0]      nt;
    logic [CNT_CFG_W-1:0] m_inc;
    logic                 wrap;
    logic                 before_stop;

    // effective period and mode count
    assign p = (cfg.period == '0) ? TIME_W'(1) : cfg.period;

    always_comb
    begin
        if (cfg.mode_count == '0)
            mode_cnt = CNT_CFG_W'(1);
        else if (cfg.mode_count > CNT_CFG_W'(MODE_MAX))
            mode_cnt = CNT_CFG_W'(MODE_MAX);
        else
            mode_cnt = cfg.mode_count;
    end

    assign cfg_end[0] = {1'b0, cfg.end0};
    assign cfg_end[1] = {1'b0, cfg.end1};
    assign cfg_end[2] = {1'b0, cfg.end2};
    assign cfg_end[3] = Q_ONE;

    // monotonic end phases, last active mode ends at one
    always_comb
    begin
        logic [Q_W:0] prev;
        logic [Q_W:0] v;
        prev = '0;
        for (int i = 0; i < MODE_MAX; i++)
        begin
            v = cfg_end[i];
            if (v < prev)
                v = prev;
            if (CNT_CFG_W'(i) + CNT_CFG_W'(1) >= mode_cnt)
                v = Q_ONE;
            mode_end[i] = v;
            prev = v;
        end
    end

    // mode that holds the start phase
    always_comb
    begin
        logic found;
        found = 1'b0;
        found_mode = MODE_W'(mode_cnt - CNT_CFG_W'(1));
        for (int i = 0; i < MODE_MAX; i++)
        begin
            if (!found && (CNT_CFG_W'(i) < mode_cnt) && ({1'b0, ph_reg} < mode_end[i]))
            begin
                found_mode = MODE_W'(i);
                found = 1'b1;
            end
        end
    end

    // restoring division step for start mod period
    assign div_shift = {r_reg, s_reg[TIME_W-1]};
    assign div_sub   = div_shift - {1'b0, p};
    assign div_ge    = div_shift >= {1'b0, p};
    assign r_next    = div_ge ? div_sub[TIME_W-1:0] : div_shift[TIME_W-1:0];

    // phase fraction step, remainder stays below period
    assign ph_diff     = {1'b0, p} - {1'b0, ph_rem_reg};
    assign ph_ge       = {1'b0, ph_rem_reg} >= ph_diff;
    assign ph_rem_next = ph_ge ? (ph_rem_reg - ph_diff[TIME_W-1:0])
                               : {ph_rem_reg[TIME_W-2:0], 1'b0};

    // boundary offset ceil(end * p / 65536) in two halves
    assign cur_end      = mode_end[m_reg];
    assign hi_prod_next = (TIME_W+1)'(cur_end) * (TIME_W+1)'(p[TIME_W-1:Q_W]);
    assign lo_prod_next = (TIME_W+1)'(cur_end) * (TIME_W+1)'(p[Q_W-1:0]);
    assign lo_adj       = lo_prod_reg + (TIME_W+1)'(17'h0FFFF);
    assign ofs_next     = hi_prod_reg + (TIME_W+1)'(lo_adj[TIME_W:Q_W]);
    assign nt           = base_reg + ofs_reg;
    assign m_inc        = {1'b0, m_reg} + CNT_CFG_W'(1);
    assign wrap         = m_inc >= mode_cnt;

    assign before_stop = t_reg < {1'b0, stop_reg};

    assign status.go_on    = before_stop && (n_reg < CNT_LIMIT);
    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            start_reg <= start_time;
            stop_reg  <= stop_time;
            s_reg     <= start_time;
            r_reg     <= '0;
        end
        if (cmd.div_step)
        begin
            s_reg <= {s_reg[TIME_W-2:0], 1'b0};
            r_reg <= r_next;
        end
        if (cmd.ph_init)
        begin
            base_reg   <= {1'b0, start_reg} - {1'b0, r_reg};
            ph_rem_reg <= r_reg;
            ph_reg     <= '0;
        end
        if (cmd.ph_step)
        begin
            ph_rem_reg <= ph_rem_next;
            ph_reg     <= {ph_reg[Q_W-2:0], ph_ge};
        end
        if (cmd.mode_init)
        begin
            m_reg     <= found_mode;
            lastm_reg <= found_mode;
            t_reg     <= {1'b0, start_reg};
            n_reg     <= '0;
        end
        if (cmd.load_brk)
        begin
            break_time_reg   <= t_reg[TIME_W-1:0];
            contact_bits_reg <= cfg.contacts[FEET*m_reg +: FEET];
            mode_index_reg   <= m_reg;
            last_item_reg    <= 1'b0;
            truncated_reg    <= 1'b0;
            lastm_reg        <= m_reg;
            n_reg            <= n_reg + CNT_W'(1);
        end
        if (cmd.mul_step)
        begin
            hi_prod_reg <= hi_prod_next;
            lo_prod_reg <= lo_prod_next;
        end
        if (cmd.ofs_step)
            ofs_reg <= ofs_next;
        if (cmd.adv_step)
        begin
            t_reg <= nt;
            if (wrap)
            begin
                m_reg    <= '0;
                base_reg <= nt;
            end
            else
            begin
                m_reg <= m_inc[MODE_W-1:0];
            end
        end
        if (cmd.load_final)
        begin
            break_time_reg   <= stop_reg;
            contact_bits_reg <= cfg.contacts[FEET*lastm_reg +: FEET];
            mode_index_reg   <= lastm_reg;
            last_item_reg    <= 1'b1;
            truncated_reg    <= before_stop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_brk || cmd.load_final)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid    = out_valid_reg;
    assign break_time   = break_time_reg;
    assign contact_bits = contact_bits_reg;
    assign mode_index   = mode_index_reg;
    assign last_item    = last_item_reg;
    assign truncated    = truncated_reg;

endmodule

// File: hw/rtl/gcs_ctrl.sv
// controller state machine sequencing division, phase and breakpoint steps
module gcs_ctrl
    import gcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  gcs_status_t status,
    output gcs_cmd_t    cmd
);

    gcs_state_t        state_reg;
    gcs_state_t        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
                if (accept)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == DIV_LAST)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                step_next  = '0;
                state_next = S_PHASE;
            end
            S_PHASE:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == PH_LAST)
                    state_next = S_MODE;
            end
            S_MODE:  state_next = S_CHECK;
            S_CHECK: state_next = status.go_on ? S_EMIT : S_FINAL;
            S_EMIT:
            begin
                if (status.out_free)
                    state_next = S_MUL;
            end
            S_MUL:   state_next = S_OFS;
            S_OFS:   state_next = S_ADV;
            S_ADV:   state_next = S_CHECK;
            S_FINAL:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:  cmd.load_in   = accept;
            S_DIV:   cmd.div_step  = 1'b1;
            S_PREP:  cmd.ph_init   = 1'b1;
            S_PHASE: cmd.ph_step   = 1'b1;
            S_MODE:  cmd.mode_init = 1'b1;
            S_EMIT:  cmd.load_brk  = status.out_free;
            S_MUL:   cmd.mul_step  = 1'b1;
            S_OFS:   cmd.ofs_step  = 1'b1;
            S_ADV:   cmd.adv_step  = 1'b1;
            S_FINAL: cmd.load_final = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

// File: hw/rtl/gait_contact_schedule.sv
// top level of the gait contact schedule block
// A request word (start_time, stop_time) yields a list of breakpoint words: one per
// gait mode boundary from the start time up to the stop time, then a final word at
// stop_time flagged last_item, with truncated set when the list was cut at
// MAX_BREAKS words. A request runs through bit-serial start mod period and
// bit-serial phase division, then per boundary through the split multiply, offset
// add and time compare (S_CHECK, S_EMIT, S_MUL, S_OFS, S_ADV), waiting whenever
// the output side stalls. The input stalls until the final word has been loaded
// into the output register; the next request is taken while that word still waits.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data; the user
// must do this only while no request is in progress: the block does not enforce it.
module gait_contact_schedule
    import gcs_pkg::*;
#(
    parameter int MAX_BREAKS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [TIME_W-1:0]     start_time,
    input  logic [TIME_W-1:0]     stop_time,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [TIME_W-1:0]     break_time,
    output logic [FEET-1:0]       contact_bits,
    output logic [MODE_W-1:0]     mode_index,
    output logic                  last_item,
    output logic                  truncated
);

    gcs_cfg_t    cfg;
    gcs_cmd_t    cmd;
    gcs_status_t status;

    gcs_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gcs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    gcs_datapath #(
        .MAX_BREAKS (MAX_BREAKS)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .start_time   (start_time),
        .stop_time    (stop_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .break_time   (break_time),
        .contact_bits (contact_bits),
        .mode_index   (mode_index),
        .last_item    (last_item),
        .truncated    (truncated)
    );

endmodule
